@@ hdl/page_frame_refcount_allocator_core_defines.svh @@
// Assertion macros shared by the page frame allocator checker.
// Depends on nothing; included by the checker file only.
`ifndef PAGE_FRAME_REFCOUNT_ALLOCATOR_CORE_DEFINES_SVH
`define PAGE_FRAME_REFCOUNT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFRA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFRA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pfra_pkg.sv @@
// Shared constants for the page frame allocator: operation and status codes,
// frame geometry and configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package pfra_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned FRAME_SHIFT = 12;

  // Bitmap words hold one "count is zero" flag per frame.
  localparam int unsigned BMP_W       = 16;
  localparam int unsigned BMP_IDX_W   = 4;

  // Signed width for frame-range arithmetic during initialize.
  localparam int unsigned RANGE_W     = 23;

  localparam logic [ADDR_W-1:0] FRAME_BASE    = 32'h0010_0000;
  localparam logic [CNT_W-1:0]  RESERVED_MARK = 7'd100;
  localparam logic signed [RANGE_W-1:0] BASE_FRAMES = 23'sd256;

  localparam logic [ADDR_W-1:0] START_RESET = 32'h0040_0000;
  localparam logic [ADDR_W-1:0] END_RESET   = 32'h0100_0000;

  // Operation codes.
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STS_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NO_FREE      = 3'd1;
  localparam logic [STATUS_W-1:0] STS_LOW_ADDR     = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NONEXISTENT  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_ALREADY_FREE = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;

endpackage

@@ hdl/page_frame_refcount_allocator_core.sv @@
// Page frame allocator with per-frame share counts, top level.
// Depends on pfra_pkg for codes and geometry.
`timescale 1ns / 1ps

// Usage:
// Commands arrive as words on the in channel (operation_i, address_i) with
// in_valid_i/in_ready_o; each command gives exactly one result word on the
// out channel (frame_address_o, status_o) with out_valid_o/out_ready_i.
// Registers start_address (index 0) and end_address (index 1) are written on
// the cfg channel, which is always ready; write them only while idle.
// The block runs one command at a time, through these states after acceptance:
//   free:       count and bitmap read, write back, deliver; straight to
//               deliver when the address is low or past end_address or the map;
//   allocate:   start, scan bitmap words from the top, then deliver; one word
//               per cycle, at most PAGE_COUNT/16 (256 at the default size);
//   initialize: prepare, sweep one count entry written per cycle, then deliver;
//   other ops:  deliver.
// The scan rate is set by the single read port of the bitmap memory.
// After reset the block sweeps both memories, with in_ready_o low, to mark
// every frame reserved.
// A finished result sits in the output register; in_ready_o returns while it
// waits, but the next result is held back until out_ready_i takes the word.
module page_frame_refcount_allocator_core
  import pfra_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           operation_i,
  input  logic [ADDR_W-1:0]    address_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ADDR_W-1:0]    frame_address_o,
  output logic [STATUS_W-1:0]  status_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i
);

  localparam int unsigned FW    = $clog2(PAGE_COUNT);
  localparam int unsigned WORDS = (PAGE_COUNT + BMP_W - 1) / BMP_W;
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [FW-1:0]  LAST_F = FW'(PAGE_COUNT - 1);
  localparam logic [WAW-1:0] LAST_W = WAW'(WORDS - 1);

  localparam logic [2:0] ST_SWEEP       = 3'd0;
  localparam logic [2:0] ST_IDLE        = 3'd1;
  localparam logic [2:0] ST_PREP        = 3'd2;
  localparam logic [2:0] ST_ALLOC_START = 3'd3;
  localparam logic [2:0] ST_ALLOC_SCAN  = 3'd4;
  localparam logic [2:0] ST_FREE_RD     = 3'd5;
  localparam logic [2:0] ST_FREE_WR     = 3'd6;
  localparam logic [2:0] ST_DELIVER     = 3'd7;

  // Control state.
  logic [2:0]                state_q, state_d;
  logic                      emit_q, emit_d;
  logic [FW-1:0]             sw_f_q, sw_f_d;
  logic [BMP_W-1:0]          acc_q, acc_d;
  logic [WAW-1:0]            chk_w_q, chk_w_d;
  logic signed [RANGE_W-1:0] first_q, first_d;
  logic signed [RANGE_W-1:0] span_q, span_d;
  logic signed [RANGE_W-1:0] hi_q, hi_d;
  logic                      out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]         cfg_start_q, cfg_end_q;

  // Payload registers.
  logic [FW-1:0]             frame_q, frame_d;
  logic [ADDR_W-1:0]         res_frame_q, res_frame_d;
  logic [STATUS_W-1:0]       res_status_q, res_status_d;
  logic [ADDR_W-1:0]         out_frame_q, out_frame_d;
  logic [STATUS_W-1:0]       out_status_q, out_status_d;

  // Memories and their ports.
  logic [CNT_W-1:0]          cnt_mem [PAGE_COUNT];
  logic [BMP_W-1:0]          bmp_mem [WORDS];
  logic                      cnt_we, bmp_we;
  logic [FW-1:0]             cnt_waddr;
  logic [CNT_W-1:0]          cnt_wdata, cnt_rdata_q;
  logic [WAW-1:0]            bmp_waddr, bmp_raddr;
  logic [BMP_W-1:0]          bmp_wdata, bmp_rdata_q;

  // Combinational helpers.
  logic                      accept;
  logic [ADDR_W-1:0]         free_off, span_c;
  logic signed [RANGE_W-1:0] sw_f_s;
  logic                      in_range;
  logic [BMP_W-1:0]          acc_next;
  logic [BMP_IDX_W-1:0]      hi_bit;
  logic [FW-1:0]             alloc_f;
  logic                      out_load;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign free_off = address_i - FRAME_BASE;
  assign span_c   = cfg_end_q - cfg_start_q;

  // Sweep position against the initialize range.
  assign sw_f_s   = RANGE_W'(sw_f_q);
  assign in_range = (sw_f_s >= first_q) && (sw_f_s < hi_q);
  assign acc_next = acc_q | (BMP_W'(in_range) << sw_f_q[BMP_IDX_W-1:0]);

  // Highest free flag in the bitmap word under test.
  always_comb begin
    hi_bit = '0;
    for (int i = 0; i < BMP_W; i++) begin
      if (bmp_rdata_q[i]) hi_bit = BMP_IDX_W'(i);
    end
  end
  assign alloc_f = FW'({chk_w_q, hi_bit});

  // Count memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata_q <= cnt_mem[frame_q];
  end

  // Free-flag bitmap memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (bmp_we) bmp_mem[bmp_waddr] <= bmp_wdata;
    bmp_rdata_q <= bmp_mem[bmp_raddr];
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    emit_d       = emit_q;
    sw_f_d       = sw_f_q;
    acc_d        = acc_q;
    chk_w_d      = chk_w_q;
    first_d      = first_q;
    span_d       = span_q;
    hi_d         = hi_q;
    frame_d      = frame_q;
    res_frame_d  = res_frame_q;
    res_status_d = res_status_q;
    cnt_we       = 1'b0;
    cnt_waddr    = sw_f_q;
    cnt_wdata    = RESERVED_MARK;
    bmp_we       = 1'b0;
    bmp_waddr    = WAW'(sw_f_q >> BMP_IDX_W);
    bmp_wdata    = acc_next;
    bmp_raddr    = WAW'(frame_q >> BMP_IDX_W);
    out_load     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_frame_d  = '0;
          res_status_d = STS_OK;
          case (operation_i)
            OP_INIT: begin
              first_d = RANGE_W'(cfg_start_q[ADDR_W-1:FRAME_SHIFT]) - BASE_FRAMES;
              span_d  = (cfg_end_q > cfg_start_q) ?
                        RANGE_W'(span_c[ADDR_W-1:FRAME_SHIFT]) : '0;
              emit_d  = 1'b1;
              state_d = ST_PREP;
            end
            OP_ALLOC: begin
              state_d = ST_ALLOC_START;
            end
            OP_FREE: begin
              if (address_i < FRAME_BASE) begin
                res_status_d = STS_LOW_ADDR;
                state_d      = ST_DELIVER;
              end else if ((address_i >= cfg_end_q) ||
                           ((free_off >> FRAME_SHIFT) >= ADDR_W'(PAGE_COUNT))) begin
                res_status_d = STS_NONEXISTENT;
                state_d      = ST_DELIVER;
              end else begin
                frame_d = FW'(free_off >> FRAME_SHIFT);
                state_d = ST_FREE_RD;
              end
            end
            default: begin
              state_d = ST_DELIVER;
            end
          endcase
        end
      end

      // Close the initialize range and start the sweep.
      ST_PREP: begin
        hi_d    = first_q + span_q;
        sw_f_d  = '0;
        acc_d   = '0;
        state_d = ST_SWEEP;
      end

      // Write one count per cycle and pack free flags into bitmap words.
      ST_SWEEP: begin
        cnt_we    = 1'b1;
        cnt_wdata = in_range ? '0 : RESERVED_MARK;
        if ((&sw_f_q[BMP_IDX_W-1:0]) || (sw_f_q == LAST_F)) begin
          bmp_we = 1'b1;
          acc_d  = '0;
        end else begin
          acc_d = acc_next;
        end
        if (sw_f_q == LAST_F) begin
          state_d = emit_q ? ST_DELIVER : ST_IDLE;
        end else begin
          sw_f_d = sw_f_q + 1'b1;
        end
      end

      ST_ALLOC_START: begin
        bmp_raddr = LAST_W;
        chk_w_d   = LAST_W;
        state_d   = ST_ALLOC_SCAN;
      end

      // Test one bitmap word per cycle while the next lower one is read.
      ST_ALLOC_SCAN: begin
        bmp_raddr = chk_w_q - 1'b1;
        if (bmp_rdata_q != '0) begin
          cnt_we       = 1'b1;
          cnt_waddr    = alloc_f;
          cnt_wdata    = CNT_W'(1);
          bmp_we       = 1'b1;
          bmp_waddr    = chk_w_q;
          bmp_wdata    = bmp_rdata_q & ~(BMP_W'(1) << hi_bit);
          res_frame_d  = FRAME_BASE + (ADDR_W'(alloc_f) << FRAME_SHIFT);
          res_status_d = STS_OK;
          state_d      = ST_DELIVER;
        end else if (chk_w_q == '0) begin
          res_status_d = STS_NO_FREE;
          state_d      = ST_DELIVER;
        end else begin
          chk_w_d = chk_w_q - 1'b1;
        end
      end

      // Count and bitmap word for frame_q are read here.
      ST_FREE_RD: begin
        state_d = ST_FREE_WR;
      end

      ST_FREE_WR: begin
        if (cnt_rdata_q == '0) begin
          res_status_d = STS_ALREADY_FREE;
        end else begin
          cnt_we    = 1'b1;
          cnt_waddr = frame_q;
          cnt_wdata = cnt_rdata_q - 1'b1;
          if (cnt_rdata_q == CNT_W'(1)) begin
            bmp_we    = 1'b1;
            bmp_waddr = WAW'(frame_q >> BMP_IDX_W);
            bmp_wdata = bmp_rdata_q | (BMP_W'(1) << frame_q[BMP_IDX_W-1:0]);
          end
        end
        state_d = ST_DELIVER;
      end

      // Hand the result to the output register once it is free.
      ST_DELIVER: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_frame_d  = out_frame_q;
    out_status_d = out_status_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_frame_d  = res_frame_q;
      out_status_d = res_status_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_address_o = out_frame_q;
  assign status_o        = out_status_q;

  // Control registers; reset starts the reserve sweep with an empty range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      emit_q      <= 1'b0;
      sw_f_q      <= '0;
      acc_q       <= '0;
      chk_w_q     <= '0;
      first_q     <= '0;
      span_q      <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      emit_q      <= emit_d;
      sw_f_q      <= sw_f_d;
      acc_q       <= acc_d;
      chk_w_q     <= chk_w_d;
      first_q     <= first_d;
      span_q      <= span_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_start_q <= START_RESET;
      cfg_end_q   <= END_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START: cfg_start_q <= cfg_data_i;
        CFG_END:   cfg_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    frame_q      <= frame_d;
    res_frame_q  <= res_frame_d;
    res_status_q <= res_status_d;
    out_frame_q  <= out_frame_d;
    out_status_q <= out_status_d;
  end

endmodule

@@ hdl/pfra_checker.sv @@
// Port-level checker for the page frame allocator and its bind statement.
// Depends on pfra_pkg and the macros in the defines header.
`timescale 1ns / 1ps
`include "page_frame_refcount_allocator_core_defines.svh"

module pfra_checker
  import pfra_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [ADDR_W-1:0]   frame_address_o,
  input logic [STATUS_W-1:0] status_o
);

  // Only one command is in flight: in_ready_o is low in the cycle after an acceptance.
  `PFRA_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input accepted on consecutive cycles")

  // A stalled result word holds.
  `PFRA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(frame_address_o) && $stable(status_o), "stalled result changed")

  // A nonzero frame address only comes with an ok status.
  `PFRA_ASSERT_IMP(a_addr_ok, clk_i, rst_ni, out_valid_o && (frame_address_o != '0), status_o == STS_OK, "frame address with error status")

  // Returned frames are page aligned and lie at or above the base.
  `PFRA_ASSERT_IMP(a_addr_shape, clk_i, rst_ni, out_valid_o && (frame_address_o != '0), (frame_address_o[FRAME_SHIFT-1:0] == '0) && (frame_address_o >= FRAME_BASE), "misaligned or low frame address")

  // Status codes stay within the defined set.
  `PFRA_ASSERT_IMP(a_status_legal, clk_i, rst_ni, out_valid_o, status_o <= STS_ALREADY_FREE, "undefined status code")

endmodule

bind page_frame_refcount_allocator_core pfra_checker u_pfra_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for page_frame_refcount_allocator_core.
// Depends on pfra_pkg and the core RTL. It keeps its own share-count map,
// predicts every result word and checks the words in order.

module tb_top;
  import pfra_pkg::*;

  localparam int unsigned PAGE_COUNT   = 4096;
  localparam longint      MAP_FRAMES   = PAGE_COUNT;
  localparam longint      FRAME_BYTES  = 64'sd1 << FRAME_SHIFT;
  localparam int unsigned OFFSET_MASK  = (1 << FRAME_SHIFT) - 1;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 120;

  // Codes that the package leaves unnamed.
  localparam logic [1:0]           OP_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]   frame;
    logic [STATUS_W-1:0] status;
  } result_word_t;

  // Block ports; the inputs are driven to known values from time zero.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           operation_i = OP_INIT;
  logic [ADDR_W-1:0]    address_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [ADDR_W-1:0]    frame_address_o;
  logic [STATUS_W-1:0]  status_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_START;
  logic [ADDR_W-1:0]    cfg_data_i  = '0;

  // Predicted state of the block.
  logic [CNT_W-1:0]  share_count [PAGE_COUNT];
  logic [ADDR_W-1:0] mem_start = START_RESET;
  logic [ADDR_W-1:0] mem_end   = END_RESET;

  result_word_t      expected_results [$];
  logic [ADDR_W-1:0] held_frames [$];
  logic [ADDR_W-1:0] freed_frames [$];

  bit          idle_on        = 1'b1;
  int unsigned holds_asked    = 0;
  int unsigned holds_served   = 0;
  int unsigned hold_left      = 0;
  int unsigned error_count    = 0;
  int unsigned sent_items     = 0;
  int unsigned init_count     = 0;
  int unsigned ranges_applied = 0;
  int unsigned status_tally [8];

  page_frame_refcount_allocator_core #(
    .PAGE_COUNT(PAGE_COUNT)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_address_o(frame_address_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Every frame back to the reserved mark.
  function automatic void reserve_all_frames();
    for (int f = 0; f < PAGE_COUNT; f++) share_count[f] = RESERVED_MARK;
  endfunction

  // Apply one command to the predicted map and return the word it yields.
  function automatic result_word_t predict_command(input logic [1:0] op,
                                                   input logic [ADDR_W-1:0] addr);
    result_word_t res;
    longint base_b, first_b, end_b, first_f, span, lo, hi;
    logic [ADDR_W-1:0] idx;
    res.frame  = '0;
    res.status = STS_OK;
    case (op)
      OP_INIT: begin
        reserve_all_frames();
        base_b  = FRAME_BASE;
        first_b = mem_start;
        end_b   = mem_end;
        // A start below the base rounds the first frame down past zero.
        if (first_b >= base_b) first_f = (first_b - base_b) >> FRAME_SHIFT;
        else first_f = -((base_b - first_b + FRAME_BYTES - 1) >> FRAME_SHIFT);
        span = (end_b > first_b) ? ((end_b - first_b) >> FRAME_SHIFT) : 0;
        lo = (first_f < 0) ? 0 : first_f;
        hi = first_f + span;
        if (hi > MAP_FRAMES) hi = MAP_FRAMES;
        for (longint f = lo; f < hi; f++) share_count[f] = '0;
      end
      OP_ALLOC: begin
        // Highest free frame wins.
        res.status = STS_NO_FREE;
        for (int f = PAGE_COUNT - 1; f >= 0; f--) begin
          if (share_count[f] == '0) begin
            share_count[f] = CNT_W'(1);
            res.frame  = FRAME_BASE + (ADDR_W'(f) << FRAME_SHIFT);
            res.status = STS_OK;
            break;
          end
        end
      end
      OP_FREE: begin
        if (addr < FRAME_BASE) begin
          res.status = STS_LOW_ADDR;
        end else begin
          idx = (addr - FRAME_BASE) >> FRAME_SHIFT;
          if (addr >= mem_end || idx >= PAGE_COUNT) res.status = STS_NONEXISTENT;
          else if (share_count[idx] != '0) share_count[idx] = share_count[idx] - 1'b1;
          else res.status = STS_ALREADY_FREE;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offer one command word, wait for acceptance and record its prediction.
  task automatic send_command(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
    result_word_t res;
    if (idle_on && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    address_i   <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = predict_command(op, addr);
    expected_results.push_back(res);
    sent_items++;
    if (op == OP_INIT) begin
      held_frames.delete();
      freed_frames.delete();
      init_count++;
    end else if (op == OP_ALLOC && res.status == STS_OK) begin
      held_frames.push_back(res.frame);
    end
  endtask

  // Stop offering and wait until every predicted word has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Write both range registers and one unmapped index; block must be idle.
  task automatic set_memory_range(input logic [ADDR_W-1:0] first_byte,
                                  input logic [ADDR_W-1:0] end_byte);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [ADDR_W-1:0]    val [3];
    idx = '{CFG_START, CFG_END, ($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO)};
    val = '{first_byte, end_byte, $urandom()};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      if (idx[i] == CFG_START) mem_start = val[i];
      else if (idx[i] == CFG_END) mem_end = val[i];
    end
    cfg_valid_i <= 1'b0;
    ranges_applied++;
  endtask

  // Free addresses outside the normal flow: low, past the end, reserved frames.
  function automatic logic [ADDR_W-1:0] stray_address();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, FRAME_BASE - 1);
      2: return mem_end + $urandom_range(0, 2 * 4096);
      3: return mem_end - $urandom_range(1, 4096);
      default: return FRAME_BASE + $urandom_range(0, (PAGE_COUNT + 2) << FRAME_SHIFT);
    endcase
  endfunction

  // Mostly allocate and release held frames, with some noise mixed in.
  task automatic send_traffic_item();
    int unsigned pick;
    int unsigned slot;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_command(OP_ALLOC, $urandom());
    end else if (pick < 74 && held_frames.size() != 0) begin
      slot = $urandom_range(0, held_frames.size() - 1);
      addr = held_frames[slot] | ($urandom() & OFFSET_MASK);
      freed_frames.push_back(held_frames[slot]);
      if (freed_frames.size() > 16) void'(freed_frames.pop_front());
      held_frames.delete(slot);
      send_command(OP_FREE, addr);
    end else if (pick < 80 && freed_frames.size() != 0) begin
      slot = $urandom_range(0, freed_frames.size() - 1);
      send_command(OP_FREE, freed_frames[slot] | ($urandom() & OFFSET_MASK));
    end else if (pick < 92) begin
      send_command(OP_FREE, stray_address());
    end else if (pick < 98) begin
      send_command(OP_UNUSED, $urandom());
    end else begin
      send_command(OP_INIT, $urandom());
    end
  endtask

  // Allocate past the last free frame when the free region is small.
  task automatic fill_map();
    int unsigned room;
    room = 0;
    for (int f = 0; f < PAGE_COUNT; f++) if (share_count[f] == '0) room++;
    if (room <= 48) repeat (room + 2) send_command(OP_ALLOC, $urandom());
  endtask

  task automatic test_directed_cases();
    // Straight after reset every frame is reserved.
    send_command(OP_ALLOC, '0);
    send_command(OP_FREE, 32'h0000_0000);
    send_command(OP_FREE, FRAME_BASE - 1);
    send_command(OP_FREE, FRAME_BASE);
    send_command(OP_FREE, END_RESET);
    send_command(OP_FREE, '1);
    send_command(OP_UNUSED, '1);
    // Default range: allocate the top frame, free it twice, take it again.
    send_command(OP_INIT, '0);
    send_command(OP_ALLOC, '1);
    send_command(OP_FREE, 32'h00FF_FFFF);
    send_command(OP_FREE, 32'h00FF_F000);
    send_command(OP_ALLOC, '0);
    // Start below the base leaves only frame zero free.
    drain_results();
    set_memory_range(32'h0000_0000, 32'h0010_1000);
    send_command(OP_INIT, '1);
    send_command(OP_ALLOC, '0);
    send_command(OP_ALLOC, '0);
    send_command(OP_FREE, 32'h0010_0ABC);
    // An end below the start frees nothing and rejects every free.
    drain_results();
    set_memory_range('1, '0);
    send_command(OP_INIT, '0);
    send_command(OP_ALLOC, '0);
    send_command(OP_FREE, FRAME_BASE);
    // Widest range: frees beyond the map, then the whole map free.
    drain_results();
    set_memory_range('0, '1);
    send_command(OP_FREE, 32'h0110_0000);
    send_command(OP_FREE, 32'hFFFF_FFFE);
    send_command(OP_INIT, '0);
    send_command(OP_ALLOC, '0);
    send_command(OP_FREE, 32'h010F_F000);
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0] first_byte;
    logic [ADDR_W-1:0] end_byte;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          // Small region somewhere in the map, sometimes clipped at the top.
          first_byte = FRAME_BASE + ($urandom_range(0, PAGE_COUNT + 8) << FRAME_SHIFT)
                       + ($urandom() & OFFSET_MASK);
          end_byte   = first_byte + ($urandom_range(1, 40) << FRAME_SHIFT)
                       + ($urandom() & OFFSET_MASK);
        end
        1: begin
          first_byte = $urandom_range(0, FRAME_BASE - 1);
          end_byte   = FRAME_BASE + ($urandom_range(0, 40) << FRAME_SHIFT)
                       + ($urandom() & OFFSET_MASK);
        end
        2: begin
          first_byte = $urandom();
          end_byte   = $urandom();
        end
        default: begin
          case (phase / 4)
            0: begin first_byte = '0; end_byte = '1; end
            1: begin first_byte = '1; end_byte = '0; end
            default: begin first_byte = $urandom(); end_byte = first_byte; end
          endcase
        end
      endcase
      drain_results();
      set_memory_range(first_byte, end_byte);
      send_command(OP_INIT, $urandom());
      fill_map();
      repeat (PHASE_ITEMS) send_traffic_item();
    end
  endtask

  task automatic test_back_to_back();
    drain_results();
    set_memory_range(32'h00F0_0000, 32'h00F1_8000);
    idle_on = 1'b0;
    send_command(OP_INIT, '0);
    fill_map();
    repeat (150) send_traffic_item();
    idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    drain_results();
    set_memory_range(START_RESET, END_RESET);
    send_command(OP_INIT, '0);
    drain_results();
    // The receiver holds off while commands keep coming, so the input stalls.
    holds_asked++;
    repeat (16) send_traffic_item();
  endtask

  // Receiver: random ready, with a long hold-off whenever one is asked for.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_ready_i  <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ready_i <= !(idle_on && $urandom_range(0, 99) < 18);
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    result_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      status_tally[status_o]++;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word: expected none, got frame %h status %0d",
                 $time, frame_address_o, status_o);
      end else begin
        want = expected_results.pop_front();
        if (frame_address_o !== want.frame) begin
          error_count++;
          $display("%0t: frame_address mismatch: expected %h, got %h",
                   $time, want.frame, frame_address_o);
        end
        if (status_o !== want.status) begin
          error_count++;
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, status_o);
        end
      end
    end
  end

  initial begin
    reserve_all_frames();
    for (int i = 0; i < 8; i++) status_tally[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Wait out the reserve sweep that follows reset.
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);

    test_directed_cases();
    test_random_traffic();
    test_back_to_back();
    test_output_backpressure();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    error_count += expected_results.size();

    $display("Covered %0d commands (%0d initializations) over %0d register settings, %0d hold-offs.",
             sent_items, init_count, ranges_applied, holds_asked);
    $display("Results: ok %0d, map full %0d, low %0d, nonexistent %0d, already free %0d.",
             status_tally[STS_OK], status_tally[STS_NO_FREE], status_tally[STS_LOW_ADDR],
             status_tally[STS_NONEXISTENT], status_tally[STS_ALREADY_FREE]);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
